>>> rtl/core/bmp3c_pkg.sv
// shared types and constants for the bmp row to three-colour pixel block
// no dependencies; imported by the front, queue, back and top modules of the block
`default_nettype none

package bmp3c_pkg;

	// configuration register indexes
	localparam logic [2:0] REG_BPP      = 3'd0;
	localparam logic [2:0] REG_WIDTH    = 3'd1;
	localparam logic [2:0] REG_HEIGHT   = 3'd2;
	localparam logic [2:0] REG_ORIGIN_X = 3'd3;
	localparam logic [2:0] REG_ORIGIN_Y = 3'd4;
	localparam logic [2:0] REG_INVERT   = 3'd5;

	// supported source depths
	localparam logic [5:0] BPP_1  = 6'd1;
	localparam logic [5:0] BPP_4  = 6'd4;
	localparam logic [5:0] BPP_8  = 6'd8;
	localparam logic [5:0] BPP_16 = 6'd16;
	localparam logic [5:0] BPP_24 = 6'd24;
	localparam logic [5:0] BPP_32 = 6'd32;

	// widest row that is ever emitted
	localparam logic [13:0] MAX_WIDTH = 14'd4096;

	// queue between front and back
	localparam int QUEUE_DEPTH = 4;

	typedef enum logic [1:0] {
		COLOR_WHITE = 2'd0,
		COLOR_BLACK = 2'd1,
		COLOR_RED   = 2'd2
	} color_t;

	// work kinds handed from front to back
	typedef enum logic [2:0] {
		OP_NONE   = 3'd0,
		OP_LOAD   = 3'd1,
		OP_INDEX1 = 3'd2,
		OP_INDEX4 = 3'd3,
		OP_INDEX8 = 3'd4,
		OP_DIRECT = 3'd5
	} op_t;

	// one queue entry: data is the palette index for a load, else the row byte
	typedef struct packed {
		op_t        op;
		logic [7:0] data;
		color_t     cls;
		logic       row_end;
	} entry_t;

	typedef struct packed {
		logic [5:0]  bpp;
		logic [12:0] width;
		logic [12:0] height;
		logic [15:0] origin_x;
		logic [15:0] origin_y;
		logic        invert;
	} cfg_t;

endpackage

`default_nettype wire

>>> rtl/core/bmp3c_ram.sv
// generic single-write, single-read ram with registered read data
// no dependencies
`default_nettype none

module bmp3c_ram #(
	parameter int WIDTH = 2,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

>>> rtl/core/bmp3c_front.sv
// front end: accepts beats, classifies palette colours, assembles direct pixels
// depends on bmp3c_pkg
`default_nettype none

module bmp3c_front import bmp3c_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire cfg_t        cfg,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic        action,
	input  wire logic [7:0]  entry_index,
	input  wire logic [23:0] entry_rgb,
	input  wire logic [7:0]  data_byte,
	input  wire logic        row_end,
	output logic             q_push,
	output entry_t           q_entry,
	input  wire logic        q_full
);

	logic [23:0] partial_q;
	logic [1:0]  bip_q;

	logic        accept;
	logic [2:0]  need;
	logic [23:0] partial_ins;
	logic        complete;
	logic [7:0]  dr, dg, db;
	op_t         op;
	color_t      cls;
	logic [23:0] partial_d;
	logic [1:0]  bip_d;

	// nearest of white, black, red by squared distance, reduced to linear tests
	function automatic color_t nearest_class(input logic [7:0] r, input logic [7:0] g,
			input logic [7:0] b);
		logic [9:0] sum;
		logic [8:0] gb;
		sum = {2'b0, r} + {2'b0, g} + {2'b0, b};
		gb  = {1'b0, g} + {1'b0, b};
		if (sum >= 10'd383 && gb >= 9'd255) begin
			return COLOR_WHITE;
		end else if (r <= 8'd127) begin
			return COLOR_BLACK;
		end
		return COLOR_RED;
	endfunction

	assign in_stall = q_full;
	assign accept   = in_valid && !q_full;

	// bytes per direct pixel
	always_comb begin
		case (cfg.bpp)
			BPP_16:  need = 3'd2;
			BPP_24:  need = 3'd3;
			BPP_32:  need = 3'd4;
			default: need = 3'd0;
		endcase
	end

	// merge the byte into the pixel being assembled
	always_comb begin
		case (bip_q)
			2'd0:    partial_ins = partial_q | {16'b0, data_byte};
			2'd1:    partial_ins = partial_q | {8'b0, data_byte, 8'b0};
			2'd2:    partial_ins = partial_q | {data_byte, 16'b0};
			default: partial_ins = partial_q;
		endcase
	end

	assign complete = (need != 3'd0) && (({1'b0, bip_q} + 3'd1) >= need);

	// channel split of the assembled pixel
	always_comb begin
		if (need == 3'd2) begin
			dr = {partial_ins[14:10], 3'b0};
			dg = {partial_ins[9:5], 3'b0};
			db = {partial_ins[4:0], 3'b0};
		end else begin
			dr = partial_ins[23:16];
			dg = partial_ins[15:8];
			db = partial_ins[7:0];
		end
	end

	// classify the beat and work out the next assembly state
	always_comb begin
		op        = OP_NONE;
		cls       = COLOR_WHITE;
		partial_d = partial_q;
		bip_d     = bip_q;
		if (!action) begin
			op  = OP_LOAD;
			cls = nearest_class(entry_rgb[23:16], entry_rgb[15:8], entry_rgb[7:0]);
		end else begin
			case (cfg.bpp)
				BPP_1:   op = OP_INDEX1;
				BPP_4:   op = OP_INDEX4;
				BPP_8:   op = OP_INDEX8;
				default: op = OP_NONE;
			endcase
			if (need != 3'd0) begin
				if (complete) begin
					op        = OP_DIRECT;
					cls       = nearest_class(dr, dg, db);
					partial_d = '0;
					bip_d     = '0;
				end else begin
					partial_d = partial_ins;
					bip_d     = bip_q + 2'd1;
				end
			end
			if (row_end) begin
				partial_d = '0;
				bip_d     = '0;
			end
		end
	end

	// queue entry
	always_comb begin
		q_entry.op      = op;
		q_entry.data    = action ? data_byte : entry_index;
		q_entry.cls     = cls;
		q_entry.row_end = action && row_end;
	end

	assign q_push = accept && (op != OP_NONE || (action && row_end));

	// pixel assembly state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			partial_q <= '0;
			bip_q     <= '0;
		end else if (accept && action) begin
			partial_q <= partial_d;
			bip_q     <= bip_d;
		end
	end

endmodule

`default_nettype wire

>>> rtl/core/bmp3c_queue.sv
// short fifo of work entries between front and back
// depends on bmp3c_pkg
`default_nettype none

module bmp3c_queue import bmp3c_pkg::*; (
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire logic   push,
	input  wire entry_t push_entry,
	output logic        full,
	input  wire logic   pop,
	output logic        head_valid,
	output entry_t      head
);

	localparam int PTR_W = $clog2(QUEUE_DEPTH);
	localparam logic [PTR_W:0] DEPTH_CNT = (PTR_W + 1)'(QUEUE_DEPTH);

	entry_t           slots [QUEUE_DEPTH];
	logic [PTR_W-1:0] wptr_q, rptr_q;
	logic [PTR_W:0]   count_q;
	logic             do_push, do_pop;

	assign full       = (count_q == DEPTH_CNT);
	assign head_valid = (count_q != '0);
	assign head       = slots[rptr_q];
	assign do_push    = push && !full;
	assign do_pop     = pop && head_valid;

	// storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			slots[wptr_q] <= push_entry;
		end
	end

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wptr_q <= (wptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wptr_q + 1'b1;
			end
			if (do_pop) begin
				rptr_q <= (rptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rptr_q + 1'b1;
			end
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

`default_nettype wire

>>> rtl/core/bmp3c_back.sv
// back end: palette writes, pixel issue with coordinates, palette read, output register
// depends on bmp3c_pkg and bmp3c_ram
`default_nettype none

module bmp3c_back import bmp3c_pkg::*; #(
	parameter int PALETTE_DEPTH = 256
) (
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire cfg_t   cfg,
	input  wire logic   head_valid,
	input  wire entry_t head,
	output logic        head_pop,
	output logic        out_valid,
	input  wire logic   out_stall,
	output logic [15:0] pixel_x,
	output logic [15:0] pixel_y,
	output logic [1:0]  pixel_color,
	output logic        last_of_run
);

	localparam int ADDR_W = $clog2(PALETTE_DEPTH);
	localparam logic [8:0] DEPTH_LIM = 9'(PALETTE_DEPTH);

	// issue state
	logic [12:0] col_q, row_q;
	logic [2:0]  sub_q;
	logic [PALETTE_DEPTH-1:0] pal_valid_q;

	// stage 1: waiting on palette read
	logic        s1_valid_q;
	logic [15:0] x_s1, y_s1;
	logic        last_s1, indexed_s1, inrange_s1;
	color_t      cls_s1;
	logic        rd_valid_q;
	logic [1:0]  ram_rdata;

	// output register
	logic        out_valid_q;
	logic [15:0] x_q, y_q;
	color_t      color_q;
	logic        last_q;

	logic        out_free, s1_free, issue;
	logic [2:0]  last_sub;
	logic        sub_last, has_px, indexed, emit, pix_last;
	logic [13:0] w14;
	logic [7:0]  idx;
	logic        idx_inrange, load_inrange;
	logic        ram_we, ram_re;
	logic [15:0] x_calc, y_calc;
	color_t      raw_cls, fin_cls;

	// handshake between stages
	assign out_free = !out_valid_q || !out_stall;
	assign s1_free  = !s1_valid_q || out_free;
	assign issue    = head_valid && s1_free;

	// last sub-pixel index of the head entry
	always_comb begin
		case (head.op)
			OP_INDEX1: last_sub = 3'd7;
			OP_INDEX4: last_sub = 3'd1;
			default:   last_sub = 3'd0;
		endcase
	end

	assign sub_last = (sub_q == last_sub);
	assign head_pop = issue && sub_last;
	assign indexed  = (head.op == OP_INDEX1) || (head.op == OP_INDEX4) ||
		(head.op == OP_INDEX8);
	assign has_px   = indexed || (head.op == OP_DIRECT);

	// row clipping against the clamped width
	assign w14      = ({1'b0, cfg.width} > MAX_WIDTH) ? MAX_WIDTH : {1'b0, cfg.width};
	assign emit     = has_px && ({1'b0, col_q} < w14);
	assign pix_last = sub_last || (({1'b0, col_q} + 14'd1) >= w14);

	// palette index of the current pixel
	always_comb begin
		case (head.op)
			OP_INDEX1: idx = {7'b0, head.data[3'd7 - sub_q]};
			OP_INDEX4: idx = sub_q[0] ? {4'b0, head.data[3:0]} : {4'b0, head.data[7:4]};
			default:   idx = head.data;
		endcase
	end

	assign idx_inrange  = ({1'b0, idx} < DEPTH_LIM);
	assign load_inrange = ({1'b0, head.data} < DEPTH_LIM);
	assign ram_we       = issue && (head.op == OP_LOAD) && load_inrange;
	assign ram_re       = issue && indexed && idx_inrange;

	// display coordinates, wrapping at 16 bits
	assign x_calc = cfg.origin_x + {3'b0, col_q};
	assign y_calc = cfg.origin_y + {3'b0, cfg.height} - 16'd1 - {3'b0, row_q};

	bmp3c_ram #(
		.WIDTH (2),
		.DEPTH (PALETTE_DEPTH)
	) u_palette (
		.clk   (clk),
		.we    (ram_we),
		.waddr (head.data[ADDR_W-1:0]),
		.wdata (head.cls),
		.re    (ram_re),
		.raddr (idx[ADDR_W-1:0]),
		.rdata (ram_rdata)
	);

	// entries never written read as white
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pal_valid_q <= '0;
			rd_valid_q  <= 1'b0;
		end else begin
			if (ram_we) begin
				pal_valid_q[head.data[ADDR_W-1:0]] <= 1'b1;
			end
			if (ram_re) begin
				rd_valid_q <= pal_valid_q[idx[ADDR_W-1:0]];
			end
		end
	end

	// column, row and sub-pixel counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
			sub_q <= '0;
		end else if (issue) begin
			sub_q <= sub_last ? 3'd0 : sub_q + 3'd1;
			if (sub_last && head.row_end) begin
				col_q <= '0;
				row_q <= row_q + 13'd1;
			end else if (emit) begin
				col_q <= col_q + 13'd1;
			end
		end
	end

	// stage 1 registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (s1_free) begin
			s1_valid_q <= issue && emit;
		end
	end

	always_ff @(posedge clk) begin
		if (issue && s1_free) begin
			x_s1       <= x_calc;
			y_s1       <= y_calc;
			last_s1    <= pix_last;
			indexed_s1 <= indexed;
			inrange_s1 <= idx_inrange;
			cls_s1     <= head.cls;
		end
	end

	// final colour with invert
	always_comb begin
		if (indexed_s1) begin
			raw_cls = (inrange_s1 && rd_valid_q) ? color_t'(ram_rdata) : COLOR_WHITE;
		end else begin
			raw_cls = cls_s1;
		end
		if (cfg.invert && raw_cls != COLOR_RED) begin
			fin_cls = color_t'({raw_cls[1], ~raw_cls[0]});
		end else begin
			fin_cls = raw_cls;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_valid_q && out_free) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_valid_q && out_free) begin
			x_q     <= x_s1;
			y_q     <= y_s1;
			color_q <= fin_cls;
			last_q  <= last_s1;
		end
	end

	assign out_valid   = out_valid_q;
	assign pixel_x     = x_q;
	assign pixel_y     = y_q;
	assign pixel_color = color_q;
	assign last_of_run = last_q;

endmodule

`default_nettype wire

>>> rtl/core/bmp_row_to_three_color_pixels.sv
// a beat's pixels pass through the queue, the stage 1 register and the output register
// throughput: one pixel per cycle from the back end's single issue slot, unless out_stall
// holds the output; a 1 bpp byte issues eight pixels, a 4 bpp byte two; palette loads use the slot too
// reset: async, clears counters, queue and palette valid bits (palette reads white)
// depends on bmp3c_pkg, bmp3c_front, bmp3c_queue, bmp3c_back
`default_nettype none

module bmp_row_to_three_color_pixels import bmp3c_pkg::*; #(
	parameter int PALETTE_DEPTH = 256
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cfg_write,
	input  wire logic [2:0]         cfg_index,
	input  wire logic [15:0]        cfg_data,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire logic               action,
	input  wire logic [7:0]         entry_index,
	input  wire logic [23:0]        entry_rgb,
	input  wire logic [7:0]         data_byte,
	input  wire logic               row_end,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output logic signed [15:0]      pixel_x,
	output logic signed [15:0]      pixel_y,
	output logic        [1:0]       pixel_color,
	output logic                    last_of_run
);

	cfg_t   cfg_q;
	logic   q_push, q_full, q_pop, head_valid;
	entry_t q_entry, head;
	logic [15:0] x_raw, y_raw;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.bpp      <= BPP_24;
			cfg_q.width    <= '0;
			cfg_q.height   <= '0;
			cfg_q.origin_x <= '0;
			cfg_q.origin_y <= '0;
			cfg_q.invert   <= 1'b0;
		end else if (cfg_write) begin
			case (cfg_index)
				REG_BPP:      cfg_q.bpp      <= cfg_data[5:0];
				REG_WIDTH:    cfg_q.width    <= cfg_data[12:0];
				REG_HEIGHT:   cfg_q.height   <= cfg_data[12:0];
				REG_ORIGIN_X: cfg_q.origin_x <= cfg_data;
				REG_ORIGIN_Y: cfg_q.origin_y <= cfg_data;
				REG_INVERT:   cfg_q.invert   <= cfg_data[0];
				default:      cfg_q          <= cfg_q;
			endcase
		end
	end

	bmp3c_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg_q),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.action      (action),
		.entry_index (entry_index),
		.entry_rgb   (entry_rgb),
		.data_byte   (data_byte),
		.row_end     (row_end),
		.q_push      (q_push),
		.q_entry     (q_entry),
		.q_full      (q_full)
	);

	bmp3c_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_entry (q_entry),
		.full       (q_full),
		.pop        (q_pop),
		.head_valid (head_valid),
		.head       (head)
	);

	bmp3c_back #(
		.PALETTE_DEPTH (PALETTE_DEPTH)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg_q),
		.head_valid  (head_valid),
		.head        (head),
		.head_pop    (q_pop),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.pixel_x     (x_raw),
		.pixel_y     (y_raw),
		.pixel_color (pixel_color),
		.last_of_run (last_of_run)
	);

	assign pixel_x = signed'(x_raw);
	assign pixel_y = signed'(y_raw);

endmodule

`default_nettype wire

>>> rtl/core/bmp3c_checker.sv
// port-level checks for the bmp row to three-colour pixel block, bound to the top
// depends on bmp_row_to_three_color_pixels
`default_nettype none

module bmp3c_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        in_valid,
	input wire logic        in_stall,
	input wire logic        out_valid,
	input wire logic        out_stall,
	input wire logic [15:0] pixel_x,
	input wire logic [15:0] pixel_y,
	input wire logic [1:0]  pixel_color,
	input wire logic        last_of_run
);

	// no output beat and no input stall once reset has been sampled low
	a_reset_quiet: assert property (@(posedge clk) !arst_n |=> !out_valid && !in_stall)
		else $error("output valid or input stall during reset");

	// a stalled result beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(pixel_x) && $stable(pixel_y) &&
		$stable(pixel_color) && $stable(last_of_run))
		else $error("stalled result beat changed");

	// only three colour codes exist
	a_color_legal: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> pixel_color != 2'd3)
		else $error("illegal colour code");

	// the queue only fills up after an input beat was taken
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(in_stall) |-> $past(in_valid && !in_stall))
		else $error("input stall rose without an accepted beat");

endmodule

bind bmp_row_to_three_color_pixels bmp3c_checker u_checker (.*);

`default_nettype wire

>>> bench/bmp3c_pixel_checker.sv
// pixel checker for the bmp row to three-colour pixel block
// watches the config port and both beat channels, predicts pixels, compares them
// depends on bmp3c_pkg for register indexes, depths, colours and the config record

module bmp3c_pixel_checker import bmp3c_pkg::*; (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cfg_write,
	input  wire logic [2:0]         cfg_index,
	input  wire logic [15:0]        cfg_data,
	input  wire logic               in_valid,
	input  wire logic               in_stall,
	input  wire logic               action,
	input  wire logic [7:0]         entry_index,
	input  wire logic [23:0]        entry_rgb,
	input  wire logic [7:0]         data_byte,
	input  wire logic               row_end,
	input  wire logic               out_valid,
	input  wire logic               out_stall,
	input  wire logic signed [15:0] pixel_x,
	input  wire logic signed [15:0] pixel_y,
	input  wire logic [1:0]         pixel_color,
	input  wire logic               last_of_run,
	output int                      failures,
	output int                      pending
);

	typedef struct packed {
		logic [15:0] x;
		logic [15:0] y;
		color_t      color;
		logic        last;
	} pixel_t;

	// shadow of the registers and of the unpacking state
	cfg_t        cfg;
	color_t      palette_cls [0:255];
	logic [23:0] partial;
	logic [1:0]  byte_pos;
	logic [12:0] col;
	logic [12:0] row;

	// pixels still owed by the block, oldest first
	pixel_t      owed_pixels [$];
	// newest pixel of the current beat, held back until its last flag is known
	pixel_t      held_px;
	bit          held;

	// nearest of white, black, red by squared distance; ties favour white, then black
	function automatic color_t nearest_color(input int r, input int g, input int b);
		int d_white, d_black, d_red;
		d_white = (255 - r) * (255 - r) + (255 - g) * (255 - g) + (255 - b) * (255 - b);
		d_black = r * r + g * g + b * b;
		d_red   = (255 - r) * (255 - r) + g * g + b * b;
		if (d_white <= d_black && d_white <= d_red)
			return COLOR_WHITE;
		if (d_black <= d_red)
			return COLOR_BLACK;
		return COLOR_RED;
	endfunction

	// one pixel at the current column, dropped past the clamped width
	task automatic place_pixel(input color_t c);
		int     lim;
		color_t shade;
		pixel_t p;
		lim = (int'(cfg.width) < int'(MAX_WIDTH)) ? int'(cfg.width) : int'(MAX_WIDTH);
		if (int'(col) < lim) begin
			shade = c;
			if (cfg.invert && c == COLOR_WHITE)
				shade = COLOR_BLACK;
			else if (cfg.invert && c == COLOR_BLACK)
				shade = COLOR_WHITE;
			p.x     = cfg.origin_x + {3'b000, col};
			p.y     = cfg.origin_y + {3'b000, cfg.height} - 16'd1 - {3'b000, row};
			p.color = shade;
			p.last  = 1'b0;
			if (held)
				owed_pixels.push_back(held_px);
			held_px = p;
			held    = 1'b1;
			col     = col + 13'd1;
		end
	endtask

	// work out the pixels of one accepted input beat
	task automatic predict_beat();
		int          need, r, g, b, k;
		logic [15:0] px;
		if (action == 1'b0) begin
			palette_cls[entry_index] = nearest_color(entry_rgb[23:16], entry_rgb[15:8],
				entry_rgb[7:0]);
		end else begin
			need = 0;
			case (cfg.bpp)
				BPP_1: begin
					for (k = 7; k >= 0; k--)
						place_pixel(palette_cls[data_byte[k]]);
				end
				BPP_4: begin
					place_pixel(palette_cls[data_byte[7:4]]);
					place_pixel(palette_cls[data_byte[3:0]]);
				end
				BPP_8:  place_pixel(palette_cls[data_byte]);
				BPP_16: need = 2;
				BPP_24: need = 3;
				BPP_32: need = 4;
				default: ;
			endcase

			// multi-byte pixels assemble little endian; the alpha byte never lands
			if (need != 0) begin
				if (byte_pos < 2'd3)
					partial = partial | (24'(data_byte) << (8 * byte_pos));
				if (int'(byte_pos) + 1 >= need) begin
					if (need == 2) begin
						px = partial[15:0];
						r  = int'(px & 16'h7C00) >> 7;
						g  = int'(px & 16'h03E0) >> 2;
						b  = int'(px & 16'h001F) << 3;
					end else begin
						b = partial[7:0];
						g = partial[15:8];
						r = partial[23:16];
					end
					place_pixel(nearest_color(r, g, b));
					partial  = '0;
					byte_pos = '0;
				end else begin
					byte_pos = byte_pos + 2'd1;
				end
			end

			// last pixel of the beat carries the run flag
			if (held) begin
				held_px.last = 1'b1;
				owed_pixels.push_back(held_px);
				held = 1'b0;
			end

			if (row_end) begin
				col      = '0;
				byte_pos = '0;
				partial  = '0;
				row      = row + 13'd1;
			end
		end
	endtask

	// compare one output beat with the oldest owed pixel
	task automatic check_pixel();
		pixel_t want;
		if (owed_pixels.size() == 0) begin
			failures++;
			$error("pixel at x %0d y %0d with no beat owing it", pixel_x, pixel_y);
		end else begin
			want = owed_pixels.pop_front();
			if (pixel_x !== want.x) begin
				failures++;
				$error("pixel_x: expected %0d, got %0d", $signed(want.x), pixel_x);
			end
			if (pixel_y !== want.y) begin
				failures++;
				$error("pixel_y: expected %0d, got %0d", $signed(want.y), pixel_y);
			end
			if (pixel_color !== want.color) begin
				failures++;
				$error("pixel_color: expected %0d, got %0d", want.color, pixel_color);
			end
			if (last_of_run !== want.last) begin
				failures++;
				$error("last_of_run: expected %0d, got %0d", want.last, last_of_run);
			end
		end
	endtask

	// outputs are checked before the beat of the same edge is predicted
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg.bpp      = BPP_24;
			cfg.width    = '0;
			cfg.height   = '0;
			cfg.origin_x = '0;
			cfg.origin_y = '0;
			cfg.invert   = 1'b0;
			foreach (palette_cls[i])
				palette_cls[i] = COLOR_WHITE;
			partial  = '0;
			byte_pos = '0;
			col      = '0;
			row      = '0;
			held     = 1'b0;
			owed_pixels.delete();
			failures = 0;
			pending  = 0;
		end else begin
			if (out_valid && !out_stall)
				check_pixel();
			if (cfg_write) begin
				case (cfg_index)
					REG_BPP:      cfg.bpp      = cfg_data[5:0];
					REG_WIDTH:    cfg.width    = cfg_data[12:0];
					REG_HEIGHT:   cfg.height   = cfg_data[12:0];
					REG_ORIGIN_X: cfg.origin_x = cfg_data;
					REG_ORIGIN_Y: cfg.origin_y = cfg_data;
					REG_INVERT:   cfg.invert   = cfg_data[0];
					default: ;
				endcase
			end
			if (in_valid && !in_stall)
				predict_beat();
			pending = owed_pixels.size();
		end
	end

endmodule

>>> bench/bmp_row_to_three_color_pixels_test.sv
// top of the bench for bmp_row_to_three_color_pixels: clock, reset, stimulus, verdict
// drives palette loads and row bytes over several image settings with random idling
// depends on bmp3c_pkg, the block itself and bmp3c_pixel_checker

module bmp_row_to_three_color_pixels_test;
	import bmp3c_pkg::*;

	logic               clk         = 1'b0;
	logic               arst_n      = 1'b0;
	logic               cfg_write   = 1'b0;
	logic [2:0]         cfg_index   = REG_BPP;
	logic [15:0]        cfg_data    = '0;
	logic               in_valid    = 1'b0;
	logic               in_stall;
	logic               action      = 1'b0;
	logic [7:0]         entry_index = '0;
	logic [23:0]        entry_rgb   = '0;
	logic [7:0]         data_byte   = '0;
	logic               row_end     = 1'b0;
	logic               out_valid;
	logic               out_stall   = 1'b0;
	logic signed [15:0] pixel_x;
	logic signed [15:0] pixel_y;
	logic [1:0]         pixel_color;
	logic               last_of_run;
	int                 failures;
	int                 pending;

	// idling switches, and the long receiver hold-off handshake
	bit tx_gaps       = 1'b0;
	bit rx_stalls     = 1'b0;
	int hold_requests = 0;
	int holds_done    = 0;
	int beats_sent    = 0;

	bmp_row_to_three_color_pixels u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_write   (cfg_write),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.action      (action),
		.entry_index (entry_index),
		.entry_rgb   (entry_rgb),
		.data_byte   (data_byte),
		.row_end     (row_end),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.pixel_x     (pixel_x),
		.pixel_y     (pixel_y),
		.pixel_color (pixel_color),
		.last_of_run (last_of_run)
	);

	bmp3c_pixel_checker u_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_write   (cfg_write),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.action      (action),
		.entry_index (entry_index),
		.entry_rgb   (entry_rgb),
		.data_byte   (data_byte),
		.row_end     (row_end),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.pixel_x     (pixel_x),
		.pixel_y     (pixel_y),
		.pixel_color (pixel_color),
		.last_of_run (last_of_run),
		.failures    (failures),
		.pending     (pending)
	);

	// clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// run length: mostly short, now and then long
	function automatic int run_length();
		int r;
		r = $urandom_range(0, 99);
		if (r < 75)
			return $urandom_range(1, 3);
		if (r < 95)
			return $urandom_range(4, 8);
		return $urandom_range(12, 40);
	endfunction

	function automatic int sender_gap();
		if (!tx_gaps || $urandom_range(0, 1) == 0)
			return 0;
		return run_length();
	endfunction

	// colour channel biased towards the extremes
	function automatic logic [7:0] channel();
		case ($urandom_range(0, 3))
			0:       return 8'h00;
			1:       return 8'hFF;
			default: return 8'($urandom);
		endcase
	endfunction

	function automatic logic [23:0] random_rgb();
		return {channel(), channel(), channel()};
	endfunction

	// palette slot that the given depth can actually reach, with some spread
	function automatic logic [7:0] palette_slot(input int bits);
		if ($urandom_range(0, 4) == 0 || bits == 8 || bits == 0)
			return 8'($urandom);
		if (bits == 1)
			return 8'($urandom_range(0, 1));
		return 8'($urandom_range(0, 15));
	endfunction

	task automatic write_reg(input logic [2:0] idx, input logic [15:0] value);
		@(negedge clk);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(negedge clk);
		cfg_write <= 1'b0;
	endtask

	task automatic set_image(input logic [5:0] depth, input logic [12:0] w, input logic [12:0] h,
		input logic [15:0] ox, input logic [15:0] oy, input logic inv);
		write_reg(REG_BPP, {10'd0, depth});
		write_reg(REG_WIDTH, {3'd0, w});
		write_reg(REG_HEIGHT, {3'd0, h});
		write_reg(REG_ORIGIN_X, ox);
		write_reg(REG_ORIGIN_Y, oy);
		write_reg(REG_INVERT, {15'd0, inv});
	endtask

	// offer one beat and hold it until accepted
	task automatic send_beat(input logic act, input logic [7:0] idx, input logic [23:0] rgb,
		input logic [7:0] b, input logic last);
		int gap;
		gap = sender_gap();
		@(negedge clk);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		action      <= act;
		entry_index <= idx;
		entry_rgb   <= rgb;
		data_byte   <= b;
		row_end     <= last;
		in_valid    <= 1'b1;
		do
			@(posedge clk);
		while (in_stall);
		beats_sent++;
	endtask

	task automatic load_entry(input logic [7:0] idx, input logic [23:0] rgb);
		send_beat(1'b0, idx, rgb, 8'($urandom), 1'($urandom));
	endtask

	task automatic row_byte(input logic [7:0] b, input logic last);
		send_beat(1'b1, 8'($urandom), 24'($urandom), b, last);
	endtask

	// wait until every owed pixel is out and the block has gone quiet
	task automatic settle();
		@(negedge clk);
		in_valid <= 1'b0;
		wait (pending == 0);
		repeat (100) @(negedge clk);
	endtask

	// one random image setting with a few rows, mostly well formed
	task automatic random_phase(input int idx);
		logic [5:0]  depth;
		logic [12:0] w, h;
		logic [15:0] ox, oy;
		logic        inv;
		int          bits, rows, row_len, j;
		case ($urandom_range(0, 6))
			0:       depth = BPP_1;
			1:       depth = BPP_4;
			2:       depth = BPP_8;
			3:       depth = BPP_16;
			4:       depth = BPP_24;
			5:       depth = BPP_32;
			default: depth = 6'($urandom_range(0, 63));
		endcase
		case ($urandom_range(0, 9))
			0:       w = '0;
			1:       w = $urandom_range(0, 1) ? 13'd4096 : 13'h1FFF;
			default: w = 13'($urandom_range(1, 20));
		endcase
		case ($urandom_range(0, 5))
			0:       h = '0;
			1:       h = 13'h1FFF;
			default: h = 13'($urandom);
		endcase
		ox = 16'($urandom);
		oy = 16'($urandom);
		if ($urandom_range(0, 4) == 0)
			ox = $urandom_range(0, 1) ? 16'h8000 : 16'h7FFF;
		if ($urandom_range(0, 4) == 0)
			oy = $urandom_range(0, 1) ? 16'h8000 : 16'h7FFF;
		inv       = 1'($urandom);
		tx_gaps   = ($urandom_range(0, 3) != 0);
		rx_stalls = ($urandom_range(0, 3) != 0);

		// first phase: dense 1 bpp rows against a long hold-off so the block backs up
		if (idx == 0) begin
			depth   = BPP_1;
			w       = 13'd64;
			tx_gaps = 1'b0;
		end
		set_image(depth, w, h, ox, oy, inv);

		case (depth)
			BPP_1:   bits = 1;
			BPP_4:   bits = 4;
			BPP_8:   bits = 8;
			BPP_16:  bits = 16;
			BPP_24:  bits = 24;
			BPP_32:  bits = 32;
			default: bits = 0;
		endcase

		repeat ((bits != 0 && bits <= 8) ? $urandom_range(1, 5) : $urandom_range(0, 1))
			load_entry(palette_slot(bits), random_rgb());

		if (idx == 0)
			hold_requests++;

		// rows padded to four bytes, some cut short or run long
		rows = (idx == 0) ? 3 : $urandom_range(1, 3);
		repeat (rows) begin
			row_len = (bits != 0) ? ((int'(w) * bits + 31) / 32) * 4 : $urandom_range(1, 8);
			if (row_len == 0)
				row_len = 4;
			if (row_len > 32)
				row_len = 32;
			if (idx != 0 && $urandom_range(0, 5) == 0)
				row_len = $urandom_range(1, row_len + 4);
			for (j = 0; j < row_len; j++) begin
				if ($urandom_range(0, 15) == 0)
					load_entry(palette_slot(bits), random_rgb());
				row_byte(8'($urandom), j == row_len - 1);
			end
		end
		settle();
	endtask

	// receiver: random stall runs, calm stretches, and the long hold-off on request
	initial begin : rx_side
		int len;
		forever begin
			@(negedge clk);
			if (holds_done < hold_requests) begin
				out_stall <= 1'b1;
				repeat (400) @(negedge clk);
				holds_done++;
			end else if (!rx_stalls) begin
				out_stall <= 1'b0;
			end else begin
				out_stall <= ($urandom_range(0, 2) == 0);
				len = run_length();
				repeat (len - 1) @(negedge clk);
			end
		end
	end

	// stimulus and verdict
	initial begin : stimulus
		int start, phase, j;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// 1 bpp at the wrapping corner of the display; second byte runs past the width
		set_image(BPP_1, 13'd12, 13'd3, 16'h8000, 16'h7FFF, 1'b0);
		load_entry(8'd0, 24'hFFFFFF);
		load_entry(8'd1, 24'h000000);
		load_entry(8'd255, 24'hFF0000);
		// white and red equally near: white wins
		load_entry(8'd2, 24'hFF00FF);
		row_byte(8'hA5, 1'b0);
		row_byte(8'hFF, 1'b1);
		settle();

		// 4 bpp inverted, last nibble past the width
		set_image(BPP_4, 13'd5, 13'd1, 16'h7FFF, 16'h8000, 1'b1);
		row_byte(8'h0F, 1'b0);
		row_byte(8'h12, 1'b0);
		row_byte(8'hFF, 1'b1);
		settle();

		// 8 bpp, invert off again
		write_reg(REG_BPP, {10'd0, BPP_8});
		write_reg(REG_INVERT, 16'd0);
		row_byte(8'hFF, 1'b0);
		row_byte(8'h02, 1'b1);
		settle();

		// x1r5g5b5: pure red, all ones, then a lone byte cut off by row end
		set_image(BPP_16, 13'd4, 13'd2, 16'd0, 16'd0, 1'b0);
		row_byte(8'h00, 1'b0);
		row_byte(8'h7C, 1'b0);
		row_byte(8'hFF, 1'b0);
		row_byte(8'h7F, 1'b0);
		row_byte(8'h55, 1'b1);
		settle();

		// 24 bpp in blue, green, red order, then an unfinished pixel
		write_reg(REG_BPP, {10'd0, BPP_24});
		row_byte(8'h00, 1'b0);
		row_byte(8'h00, 1'b0);
		row_byte(8'hFF, 1'b0);
		row_byte(8'h12, 1'b1);
		settle();

		// depth drops from 32 to 16 bpp with three bytes already gathered
		write_reg(REG_BPP, {10'd0, BPP_32});
		row_byte(8'h11, 1'b0);
		row_byte(8'h22, 1'b0);
		row_byte(8'h33, 1'b0);
		settle();
		write_reg(REG_BPP, {10'd0, BPP_16});
		row_byte(8'h44, 1'b0);
		settle();

		// unsupported depth: nothing comes out, row end still counts
		write_reg(REG_BPP, 16'd2);
		row_byte(8'hAA, 1'b1);
		settle();

		// random settings and rows
		start = beats_sent;
		phase = 0;
		while (beats_sent - start < 240) begin
			random_phase(phase);
			phase++;
		end

		// widest setting: width clamps to the maximum, a 1 bpp row stays well inside it
		tx_gaps   = 1'b0;
		rx_stalls = 1'b1;
		set_image(BPP_1, 13'h1FFF, 13'd2, 16'd0, 16'd0, 1'b0);
		load_entry(8'd1, 24'h000000);
		for (j = 0; j < 40; j++)
			row_byte(8'($urandom), j == 39);
		settle();

		if (failures == 0)
			$display("bmp_row_to_three_color_pixels_test passed");
		else
			$display("bmp_row_to_three_color_pixels_test failed");
		$finish;
	end

	// overall time limit
	initial begin : watchdog
		#10000000;
		$display("bmp_row_to_three_color_pixels_test failed");
		$finish;
	end

endmodule

>>> sim.f
rtl/core/bmp3c_pkg.sv
rtl/core/bmp3c_ram.sv
rtl/core/bmp3c_front.sv
rtl/core/bmp3c_queue.sv
rtl/core/bmp3c_back.sv
rtl/core/bmp_row_to_three_color_pixels.sv
rtl/core/bmp3c_checker.sv
bench/bmp3c_pixel_checker.sv
bench/bmp_row_to_three_color_pixels_test.sv
